// ----- rtl/core/cht_pkg.sv -----
`default_nettype none
package cht_pkg;

  // table geometry; BUCKETS must be a power of two so the hash is a mask
  localparam int BUCKETS    = 16;
  localparam int POOL_NODES = 64;

  localparam int KEY_W    = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int BUCKET_W = 4;

  localparam int BKT_W = $clog2(BUCKETS);
  localparam int IDX_W = $clog2(POOL_NODES);
  localparam int PTR_W = $clog2(POOL_NODES + 1);

  // null link is the pool size itself
  localparam logic [PTR_W-1:0] NIL_PTR = PTR_W'(POOL_NODES);

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [BKT_W-1:0] bkt_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  // node pool write port
  typedef struct packed {
    logic we_key;
    logic we_link;
    idx_t addr;
    key_t key;
    ptr_t link;
  } mem_wr_t;

  function automatic logic ptr_valid(input ptr_t p);
    return p < NIL_PTR;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/cht_if.sv -----
`default_nettype none
interface cht_in_if import cht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_W-1:0]    key;

  modport source (output valid, output cmd, output key, input ready);
  modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface cht_out_if import cht_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BUCKET_W-1:0] bucket;

  modport source (output valid, output status, output bucket, input ready);
  modport sink   (input valid, input status, input bucket, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/cht_node_ram.sv -----
`default_nettype none
module cht_node_ram import cht_pkg::*; (
  input  wire logic    clk,
  input  wire mem_wr_t wr,
  input  wire idx_t    rd_addr,
  output key_t         rd_key,
  output ptr_t         rd_link
);

  key_t key_mem  [POOL_NODES];
  ptr_t link_mem [POOL_NODES];

  // key and link arrays share one address, separate enables
  always_ff @(posedge clk) begin
    if (wr.we_key) begin
      key_mem[wr.addr] <= wr.key;
    end
    if (wr.we_link) begin
      link_mem[wr.addr] <= wr.link;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_key  <= key_mem[rd_addr];
    rd_link <= link_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/cht_ctrl.sv -----
`default_nettype none
module cht_ctrl import cht_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  cht_in_if.sink     in_if,
  cht_out_if.source  out_if,
  output mem_wr_t    mem_wr,
  output idx_t       rd_addr,
  input  wire key_t  rd_key,
  input  wire ptr_t  rd_link
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_START = 6'b000010,
    S_ALLOC = 6'b000100,
    S_CMP   = 6'b001000,
    S_FREE  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  cmd_t    cmd_r;
  key_t    key_r;
  bkt_t    bkt_r;
  ptr_t    cur_r, cur_nxt;
  ptr_t    prev_r, prev_nxt;
  ptr_t    free_head_r, free_head_nxt;
  ptr_t    nuc_r, nuc_nxt;
  status_t st_r, st_nxt;
  ptr_t    heads_r [BUCKETS];
  logic    heads_we;
  ptr_t    heads_val;

  logic    out_valid_r;
  status_t out_status_r;
  bkt_t    out_bkt_r;
  logic    out_free;
  logic    accept;
  logic    key_hit;
  ptr_t    head_cur;

  assign accept      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_if.ready;
  assign head_cur    = heads_r[bkt_r];
  // the shared comparator of the chain walk
  assign key_hit     = (rd_key == key_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    free_head_nxt = free_head_r;
    nuc_nxt       = nuc_r;
    st_nxt        = st_r;
    heads_we      = 1'b0;
    heads_val     = head_cur;
    rd_addr       = cur_r[IDX_W-1:0];
    mem_wr        = '{we_key: 1'b0, we_link: 1'b0, addr: cur_r[IDX_W-1:0],
                      key: key_r, link: head_cur};
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        state_nxt = S_DONE;
        st_nxt    = ST_NOT_FOUND;
        prev_nxt  = NIL_PTR;
        cur_nxt   = head_cur;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (ptr_valid(free_head_r)) begin
              // fetch the free node's link first
              rd_addr   = free_head_r[IDX_W-1:0];
              state_nxt = S_ALLOC;
            end else if (nuc_r < NIL_PTR) begin
              mem_wr.we_key  = 1'b1;
              mem_wr.we_link = 1'b1;
              mem_wr.addr    = nuc_r[IDX_W-1:0];
              heads_we       = 1'b1;
              heads_val      = nuc_r;
              nuc_nxt        = nuc_r + PTR_W'(1);
              st_nxt         = ST_INSERTED;
            end else begin
              st_nxt = ST_FULL;
            end
          end
          CMD_SEARCH, CMD_DELETE: begin
            if (ptr_valid(head_cur)) begin
              rd_addr   = head_cur[IDX_W-1:0];
              state_nxt = S_CMP;
            end
          end
          default: begin
            st_nxt = ST_NOT_FOUND;
          end
        endcase
      end
      S_ALLOC: begin
        // pop the free list and link the node at the chain head
        mem_wr.we_key  = 1'b1;
        mem_wr.we_link = 1'b1;
        mem_wr.addr    = free_head_r[IDX_W-1:0];
        heads_we       = 1'b1;
        heads_val      = free_head_r;
        free_head_nxt  = rd_link;
        st_nxt         = ST_INSERTED;
        state_nxt      = S_DONE;
      end
      S_CMP: begin
        if (key_hit) begin
          if (cmd_r == CMD_SEARCH) begin
            st_nxt    = ST_FOUND;
            state_nxt = S_DONE;
          end else begin
            // unlink from predecessor or chain head
            if (ptr_valid(prev_r)) begin
              mem_wr.we_link = 1'b1;
              mem_wr.addr    = prev_r[IDX_W-1:0];
              mem_wr.link    = rd_link;
            end else begin
              heads_we  = 1'b1;
              heads_val = rd_link;
            end
            state_nxt = S_FREE;
          end
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = rd_link;
          rd_addr  = rd_link[IDX_W-1:0];
          if (!ptr_valid(rd_link)) begin
            st_nxt    = ST_NOT_FOUND;
            state_nxt = S_DONE;
          end
        end
      end
      S_FREE: begin
        // push the removed node onto the free list
        mem_wr.we_link = 1'b1;
        mem_wr.addr    = cur_r[IDX_W-1:0];
        mem_wr.link    = free_head_r;
        free_head_nxt  = cur_r;
        st_nxt         = ST_DELETED;
        state_nxt      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= NIL_PTR;
      nuc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      nuc_r       <= nuc_nxt;
    end
  end

  // chain heads
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BUCKETS; i++) begin
        heads_r[i] <= NIL_PTR;
      end
    end else if (heads_we) begin
      heads_r[bkt_r] <= heads_val;
    end
  end

  // command beat and walk pointers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd_t'(in_if.cmd);
      key_r <= in_if.key;
      bkt_r <= in_if.key[BKT_W-1:0];
    end
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    st_r   <= st_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_status_r <= st_r;
      out_bkt_r    <= bkt_r;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.status = out_status_r;
  assign out_if.bucket = BUCKET_W'(out_bkt_r);

`ifndef SYNTHESIS
  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= NIL_PTR) else $error("free list head out of range");
  a_nuc_range: assert property (@(posedge clk) disable iff (!rst_n)
    nuc_r <= NIL_PTR) else $error("pool fill count out of range");
  a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_START) else $error("accepted beat not started");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=> out_valid_r && state_r == S_IDLE)
    else $error("result not loaded on completion");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/chained_hash_table_top.sv -----
`default_nettype none
// chained hash table with separate chaining over a fixed node pool
// in_if carries a command beat (cmd: insert, search, delete; key: 32 bits),
// out_if returns one result beat per command (status, bucket = key mod 16).
// both channels use valid/ready; a beat moves when both are high.
// one command is in flight at a time; in_if.ready is high only when idle.
// steps from acceptance to out_if.valid, each ending in the done step:
//   insert from never-used slots, pool full or unused command: start
//   insert reusing a freed node: start, alloc (reads the free link)
//   search or delete: start, then a compare step for each chain node
//   visited, then a free step for a delete that unlinks a node
// in_if.ready returns together with out_if.valid, so the next command is
// accepted no earlier than the previous result is offered.
// the chain walk is bound by the single registered read port of the node
// memory and the one key comparator, one node per cycle.
// a result waits in an output register; a stalled receiver holds the
// block in its final step, so no beat is lost or repeated.
// synchronous reset empties every chain, the free list and the pool fill
// count at once; node memory needs no clearing.
module chained_hash_table_top import cht_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cht_in_if.sink    in_if,
  cht_out_if.source out_if
);

  mem_wr_t mem_wr;
  idx_t    rd_addr;
  key_t    rd_key;
  ptr_t    rd_link;

  // sequencer and chain heads
  cht_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .mem_wr  (mem_wr),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_link (rd_link)
  );

  // node pool keys and links
  cht_node_ram u_ram (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_link (rd_link)
  );

endmodule
`default_nettype wire

// ----- tb/sv/tb_chained_hash_table_top.sv -----
`timescale 1ns / 1ps

module tb_chained_hash_table_top;
  import cht_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_ITEMS   = 500;
  localparam int PHASE_ITEMS  = 125;
  localparam int MODE_ITEMS   = 80;
  localparam int KEY_SET_N    = 24;
  localparam int DIR_ROWS     = 22;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT  = 400000;

  // traffic mix per stretch of random commands
  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN} traffic_mix_t;

  typedef struct packed {
    status_t             status;
    logic [BUCKET_W-1:0] bucket;
  } table_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    op;
    key_t                k;
    logic                typed;
    status_t             status;
    logic [BUCKET_W-1:0] bucket;
  } stim_row_t;

  // directed commands; typed rows carry their own expected result
  stim_row_t dir_rows [DIR_ROWS] = '{
    '{CMD_SEARCH, 32'h0000_0000, 1'b1, ST_NOT_FOUND, 4'h0},
    '{CMD_DELETE, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 4'hF},
    '{CMD_UNUSED, 32'h1234_5677, 1'b1, ST_NOT_FOUND, 4'h7},
    '{CMD_INSERT, 32'h0000_0000, 1'b1, ST_INSERTED,  4'h0},
    '{CMD_INSERT, 32'hFFFF_FFFF, 1'b1, ST_INSERTED,  4'hF},
    '{CMD_INSERT, 32'h0000_0010, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_INSERT, 32'h0000_0010, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_SEARCH, 32'h0000_0000, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_SEARCH, 32'h0000_0020, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_DELETE, 32'h0000_0010, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_SEARCH, 32'h0000_0010, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_DELETE, 32'h0000_0000, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_DELETE, 32'h0000_0000, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_INSERT, 32'hAAAA_AAAA, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_INSERT, 32'h5555_5555, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_SEARCH, 32'hAAAA_AAAA, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, ST_NOT_FOUND, 4'hF},
    '{CMD_DELETE, 32'h0000_0010, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_DELETE, 32'h0000_0010, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_DELETE, 32'hFFFF_FFFF, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_SEARCH, 32'h5555_5555, 1'b0, ST_INSERTED,  4'h0},
    '{CMD_SEARCH, 32'h8000_0001, 1'b0, ST_INSERTED,  4'h0}
  };

  logic clk;
  logic rst_n;

  cht_in_if  in_ch ();
  cht_out_if out_ch ();

  chained_hash_table_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // shadow copy of the table
  ptr_t chain_head [BUCKETS];
  key_t node_key   [POOL_NODES];
  ptr_t node_next  [POOL_NODES];
  ptr_t free_top;
  int   fresh_count;

  table_result_t pending_results [$];
  table_result_t oldest_expected;
  key_t          key_set [KEY_SET_N];
  int            send_idle_pct;
  int            recv_stall_pct;
  int            bad_beats;
  int            cycle_count;

  // applies one command to the shadow table and returns its result
  function automatic table_result_t apply_table_op(input logic [CMD_W-1:0] op, input key_t k);
    table_result_t r;
    bkt_t          b;
    ptr_t          cur;
    ptr_t          prev;
    ptr_t          n;
    int            steps;
    logic          hit;
    b        = bkt_t'(k % BUCKETS);
    r.bucket = BUCKET_W'(k % BUCKETS);
    r.status = ST_NOT_FOUND;
    case (op)
      CMD_INSERT: begin
        // free list first, then never-used slots
        if (free_top != NIL_PTR) begin
          n        = free_top;
          free_top = node_next[n];
        end else if (fresh_count < POOL_NODES) begin
          n = ptr_t'(fresh_count);
          fresh_count++;
        end else begin
          n = NIL_PTR;
        end
        if (n == NIL_PTR) begin
          r.status = ST_FULL;
        end else begin
          node_key[n]   = k;
          node_next[n]  = chain_head[b];
          chain_head[b] = n;
          r.status      = ST_INSERTED;
        end
      end
      CMD_SEARCH: begin
        cur   = chain_head[b];
        steps = 0;
        hit   = 1'b0;
        while (cur != NIL_PTR && steps < POOL_NODES && !hit) begin
          if (node_key[cur] == k) hit = 1'b1;
          else cur = node_next[cur];
          steps++;
        end
        if (hit) r.status = ST_FOUND;
      end
      CMD_DELETE: begin
        // unlink the newest match and push it on the free list
        cur   = chain_head[b];
        prev  = NIL_PTR;
        steps = 0;
        hit   = 1'b0;
        while (cur != NIL_PTR && steps < POOL_NODES && !hit) begin
          if (node_key[cur] == k) begin
            hit = 1'b1;
          end else begin
            prev = cur;
            cur  = node_next[cur];
          end
          steps++;
        end
        if (hit) begin
          if (prev != NIL_PTR) node_next[prev] = node_next[cur];
          else chain_head[b] = node_next[cur];
          node_next[cur] = free_top;
          free_top       = cur;
          r.status       = ST_DELETED;
        end
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    return r;
  endfunction

  // drives one command beat and queues its expected result on acceptance
  task automatic send_command(input logic [CMD_W-1:0] op, input key_t k,
                              input logic typed, input table_result_t typed_res);
    table_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd   <= op;
    in_ch.key   <= k;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predicted = apply_table_op(op, k);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result beat checker
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing pending: status %0d bucket %0d",
               out_ch.status, out_ch.bucket);
        bad_beats++;
      end else begin
        oldest_expected = pending_results.pop_front();
        if (out_ch.status !== oldest_expected.status) begin
          $error("status: expected %0d, got %0d", oldest_expected.status, out_ch.status);
          bad_beats++;
        end
        if (out_ch.bucket !== oldest_expected.bucket) begin
          $error("bucket: expected %0d, got %0d", oldest_expected.bucket, out_ch.bucket);
          bad_beats++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus
  initial begin
    table_result_t typed_res;
    traffic_mix_t  mix;
    logic [CMD_W-1:0] op;
    key_t          k;
    int            roll;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.cmd      = CMD_INSERT;
    in_ch.key      = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    for (int b = 0; b < BUCKETS; b++) chain_head[b] = NIL_PTR;
    free_top    = NIL_PTR;
    fresh_count = 0;
    for (int j = 0; j < KEY_SET_N; j++) key_set[j] = $urandom;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    for (int r = 0; r < DIR_ROWS; r++) begin
      typed_res.status = dir_rows[r].status;
      typed_res.bucket = dir_rows[r].bucket;
      send_command(dir_rows[r].op, dir_rows[r].k, dir_rows[r].typed, typed_res);
    end

    // random traffic: stretches that fill the pool, mix and drain, in rotation
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % PHASE_ITEMS == 0) begin
        case (i / PHASE_ITEMS)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
          default: begin send_idle_pct = 26; recv_stall_pct = 26; end
        endcase
      end
      mix  = traffic_mix_t'((i / MODE_ITEMS) % 3);
      roll = $urandom_range(99);
      case (mix)
        MIX_FILL: begin
          if (roll < 90) op = CMD_INSERT;
          else if (roll < 95) op = CMD_SEARCH;
          else op = CMD_DELETE;
        end
        MIX_BALANCED: begin
          if (roll < 40) op = CMD_INSERT;
          else if (roll < 70) op = CMD_SEARCH;
          else if (roll < 95) op = CMD_DELETE;
          else op = CMD_UNUSED;
        end
        default: begin
          if (roll < 10) op = CMD_INSERT;
          else if (roll < 20) op = CMD_SEARCH;
          else if (roll < 97) op = CMD_DELETE;
          else op = CMD_UNUSED;
        end
      endcase
      // mostly recurring keys so searches and deletes hit
      if ($urandom_range(99) < 85) k = key_set[$urandom_range(KEY_SET_N - 1)];
      else k = $urandom;
      typed_res = '0;
      send_command(op, k, 1'b0, typed_res);
    end
    in_ch.valid <= 1'b0;

    // wait for the last results, then let the block settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_beats == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/cht_pkg.sv
rtl/core/cht_if.sv
rtl/core/cht_node_ram.sv
rtl/core/cht_ctrl.sv
rtl/core/chained_hash_table_top.sv
tb/sv/tb_chained_hash_table_top.sv
